FILE: rtl/core/lmcd_pkg.sv
`default_nettype none
package lmcd_pkg;

  // Pixel layout: blue 23..16, green 15..8, red 7..0; one byte is one digit
  localparam int PIX_W      = 24;
  localparam int DIGIT_W    = 8;
  localparam int GAIN_W     = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [3:0] DATA_WORD_BITS = 4'd8;
  localparam logic [3:0] GAIN_WORD_BITS = 4'd6;
  localparam logic [3:0] NO_WORD_BITS   = 4'd0;

  // Eight rows (or gain groups) of three digits per run
  localparam logic [2:0] LAST_ROW   = 3'd7;
  localparam logic [1:0] LAST_DIGIT = 2'd2;
  localparam logic [2:0] ROW_STEP   = 3'd2;

  localparam logic KIND_SHIFT = 1'b0;
  localparam logic KIND_LINE  = 1'b1;

  localparam logic [1:0] REG_GAIN_FIRST  = 2'd0;
  localparam logic [1:0] REG_GAIN_SECOND = 2'd1;
  localparam logic [1:0] REG_GAIN_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_SEND  = 2'd1,
    FUNC_INIT  = 2'd2,
    FUNC_LINE  = 2'd3
  } func_t;

  typedef struct packed {
    logic       rd_en;
    logic [2:0] rd_row;
    logic       ld_pixel;
    logic       ld_gain;
    logic       shift;
    logic       push;
    logic       first;
    logic       last;
    func_t      mode;
  } lmcd_seq_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] shift_word;
    logic [3:0] word_bits;
    logic       latch_before;
    logic       latch_after;
    logic       chip_reset_pulse;
    logic       bank_select;
    logic [7:0] line_onehot;
    logic       last;
  } lmcd_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/lmcd_in_if.sv
`default_nettype none
interface lmcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] column;
  logic [2:0] row;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       line_enable;

  modport source (
    output valid, func, column, row, red, green, blue, line_enable,
    input  ready
  );
  modport sink (
    input  valid, func, column, row, red, green, blue, line_enable,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/lmcd_out_if.sv
`default_nettype none
interface lmcd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] shift_word;
  logic [3:0] word_bits;
  logic       latch_before;
  logic       latch_after;
  logic       chip_reset_pulse;
  logic       bank_select;
  logic [7:0] line_onehot;
  logic       last;

  modport source (
    output valid, kind, shift_word, word_bits, latch_before, latch_after,
           chip_reset_pulse, bank_select, line_onehot, last,
    input  ready
  );
  modport sink (
    input  valid, kind, shift_word, word_bits, latch_before, latch_after,
           chip_reset_pulse, bank_select, line_onehot, last,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/lmcd_ram.sv
`default_nettype none
module lmcd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/lmcd_digit_shift.sv
`default_nettype none
module lmcd_digit_shift (
  input  logic                        clk,
  input  logic                        load,
  input  logic [lmcd_pkg::PIX_W-1:0]  load_value,
  input  logic                        shift,
  output logic [lmcd_pkg::DIGIT_W-1:0] digit
);
  import lmcd_pkg::*;

  logic [PIX_W-1:0] sh_r;
  logic [PIX_W-1:0] sh_nxt;

  // Advance one byte per emitted word; reload at the end of a row
  always_comb begin
    sh_nxt = sh_r;
    priority if (load) begin
      sh_nxt = load_value;
    end else if (shift) begin
      sh_nxt = {sh_r[PIX_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign digit = sh_r[PIX_W-1 -: DIGIT_W];

endmodule
`default_nettype wire

FILE: rtl/core/lmcd_seq.sv
`default_nettype none
module lmcd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lmcd_pkg::func_t     func,
  input  logic                slot_free,
  output logic                idle,
  output lmcd_pkg::lmcd_seq_t ctrl
);
  import lmcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } lmcd_state_t;

  lmcd_state_t state_r, state_nxt;
  func_t       mode_r, mode_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [1:0]  digit_r, digit_nxt;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    digit_nxt     = digit_r;
    ctrl          = '0;
    ctrl.mode     = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = func;
          row_nxt   = '0;
          digit_nxt = '0;
          unique case (func)
            FUNC_SEND: begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_row = '0;
              state_nxt   = ST_FETCH;
            end
            FUNC_INIT: begin
              ctrl.ld_gain = 1'b1;
              state_nxt    = ST_EMIT;
            end
            FUNC_LINE: begin
              state_nxt = ST_EMIT;
            end
            FUNC_PIXEL: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Row 0 is in the read register; prefetch row 1
        ctrl.ld_pixel = 1'b1;
        ctrl.rd_en    = 1'b1;
        ctrl.rd_row   = 3'd1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          ctrl.push  = 1'b1;
          ctrl.first = (row_r == '0) && (digit_r == '0);
          ctrl.last  = (mode_r == FUNC_LINE) ||
                       ((row_r == LAST_ROW) && (digit_r == LAST_DIGIT));
          if (ctrl.last) begin
            state_nxt = ST_IDLE;
          end else if (digit_r == LAST_DIGIT) begin
            digit_nxt = '0;
            row_nxt   = row_r + 3'd1;
            if (mode_r == FUNC_SEND) begin
              ctrl.ld_pixel = 1'b1;
              ctrl.rd_en    = (row_r < (LAST_ROW - 3'd1));
              ctrl.rd_row   = row_r + ROW_STEP;
            end else begin
              ctrl.ld_gain = 1'b1;
            end
          end else begin
            digit_nxt  = digit_r + 2'd1;
            ctrl.shift = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= FUNC_PIXEL;
      row_r   <= '0;
      digit_r <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      row_r   <= row_nxt;
      digit_r <= digit_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/led_matrix_column_driver_top.sv
`default_nettype none
// 8x8 RGB LED matrix column driver.
// Input channel in_ch carries one command per transaction: pixel write, column
// send, brightness init or line select. Result channel out_ch carries the words
// to shift out on the driver's data pin plus latch, chip reset, bank select and
// line levels; last marks the final word of a command. Gains are written over
// the APB port (byte address 0, 4, 8); the user must write them only while the
// block is idle, which the block itself does not enforce. Words per command:
//   pixel write    none
//   column send    24: accept, one frame store fetch, then one word a cycle
//                  out of a 24-bit byte shift register (receiver always ready)
//   brightness     24, same shift register
//   line select    one
// One command is in work at a time; the next is taken as soon as the last word
// sits in the output register, even if the receiver has not yet taken it.
// A stalled receiver holds the output register and freezes the word sequence.
// Reset clears the frame store valid bits (all pixels read as zero at once,
// no clearing pass), bank select and active line, and sets all gains to 63.
module led_matrix_column_driver_top #(
  parameter int MATRIX_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lmcd_in_if.sink                         in_ch,
  lmcd_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmcd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lmcd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lmcd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lmcd_pkg::*;

  localparam int DEPTH = MATRIX_SIZE * MATRIX_SIZE;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [GAIN_W-1:0] gain_first_r, gain_second_r, gain_third_r;
  logic              cfg_wr;

  // Block state
  logic             bank_r;
  logic [7:0]       line_r;
  logic [2:0]       col_r;
  logic [2:0]       col_sel;
  logic [DEPTH-1:0] valid_r;
  logic             px_ok_r;

  // Handshake and sequencing
  logic         in_ready;
  logic         in_acc;
  logic         start;
  func_t        in_func;
  lmcd_seq_t    seq;
  logic         slot_free;
  logic         out_valid_r;
  lmcd_result_t out_res_r;
  lmcd_result_t res_nxt;

  // Frame store access
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_in_range;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  pixel;
  logic [PIX_W-1:0]  load_value;
  logic [DIGIT_W-1:0] digit;
  logic [7:0]        line_nxt;

  // ---------------------------------------------------------------------------
  // APB configuration: writes complete in the access phase, reads are direct
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_first_r  <= '1;
      gain_second_r <= '1;
      gain_third_r  <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GAIN_FIRST:  gain_first_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN_SECOND: gain_second_r <= pwdata[GAIN_W-1:0];
        REG_GAIN_THIRD:  gain_third_r  <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GAIN_FIRST:  prdata = CFG_DATA_W'(gain_first_r);
      REG_GAIN_SECOND: prdata = CFG_DATA_W'(gain_second_r);
      REG_GAIN_THIRD:  prdata = CFG_DATA_W'(gain_third_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side: take a command only while the sequencer is idle
  // ---------------------------------------------------------------------------
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign in_func     = func_t'(in_ch.func);
  assign start       = in_acc && (in_func != FUNC_PIXEL);

  // Pixel writes outside the matrix are dropped
  assign wr_en   = in_acc && (in_func == FUNC_PIXEL) &&
                   (int'(in_ch.column) < MATRIX_SIZE) && (int'(in_ch.row) < MATRIX_SIZE);
  assign wr_addr = AW'(in_ch.column) * AW'(MATRIX_SIZE) + AW'(in_ch.row);

  // A closed line, or a column outside the matrix, turns all lines off
  assign line_nxt = (in_ch.line_enable && (int'(in_ch.column) < MATRIX_SIZE)) ?
                    (8'b1 << in_ch.column) : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      line_r  <= '0;
      valid_r <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (in_acc && (in_func == FUNC_INIT)) begin
        bank_r <= 1'b1;
        line_r <= '0;
      end
      if (in_acc && (in_func == FUNC_LINE)) begin
        line_r <= line_nxt;
      end
    end
  end

  // Hold the column of the command for the whole send
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r <= in_ch.column;
    end
  end

  // Row 0 is fetched in the accepting cycle, before col_r has the new column
  assign col_sel = in_acc ? in_ch.column : col_r;

  // ---------------------------------------------------------------------------
  // Sequencer (send): fetch a row, emit 3 bytes, reload from the prefetched row
  // ---------------------------------------------------------------------------
  lmcd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_func),
    .slot_free (slot_free),
    .idle      (in_ready),
    .ctrl      (seq)
  );

  // ---------------------------------------------------------------------------
  // Frame store: rows beyond the matrix and unwritten pixels read as zero
  // ---------------------------------------------------------------------------
  assign rd_addr     = AW'(col_sel) * AW'(MATRIX_SIZE) + AW'(seq.rd_row);
  assign rd_in_range = (int'(col_sel) < MATRIX_SIZE) && (int'(seq.rd_row) < MATRIX_SIZE);

  lmcd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_ch.blue, in_ch.green, in_ch.red}),
    .re    (seq.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Track whether the registered read data is a real pixel
  always_ff @(posedge clk) begin
    if (seq.rd_en) begin
      px_ok_r <= rd_in_range && valid_r[rd_addr];
    end
  end

  assign pixel = px_ok_r ? ram_rdata : '0;

  // Gains go out as bytes with the top two bits clear
  assign load_value = seq.ld_gain ?
                      {2'b00, gain_first_r, 2'b00, gain_second_r, 2'b00, gain_third_r} :
                      pixel;

  lmcd_digit_shift u_shift (
    .clk        (clk),
    .load       (seq.ld_pixel || seq.ld_gain),
    .load_value (load_value),
    .shift      (seq.shift),
    .digit      (digit)
  );

  // ---------------------------------------------------------------------------
  // Output register: parts the sequencer from the receiver
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    res_nxt                  = '0;
    res_nxt.bank_select      = bank_r;
    res_nxt.line_onehot      = line_r;
    res_nxt.last             = seq.last;
    unique case (seq.mode)
      FUNC_SEND: begin
        res_nxt.kind         = KIND_SHIFT;
        res_nxt.shift_word   = digit;
        res_nxt.word_bits    = DATA_WORD_BITS;
        res_nxt.latch_before = seq.first;
        res_nxt.latch_after  = seq.last;
      end
      FUNC_INIT: begin
        res_nxt.kind             = KIND_SHIFT;
        res_nxt.shift_word       = digit;
        res_nxt.word_bits        = GAIN_WORD_BITS;
        res_nxt.chip_reset_pulse = seq.first;
      end
      FUNC_LINE: begin
        res_nxt.kind      = KIND_LINE;
        res_nxt.word_bits = NO_WORD_BITS;
      end
      FUNC_PIXEL: begin
        res_nxt.kind = KIND_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.push) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = out_res_r.kind;
  assign out_ch.shift_word       = out_res_r.shift_word;
  assign out_ch.word_bits        = out_res_r.word_bits;
  assign out_ch.latch_before     = out_res_r.latch_before;
  assign out_ch.latch_after      = out_res_r.latch_after;
  assign out_ch.chip_reset_pulse = out_res_r.chip_reset_pulse;
  assign out_ch.bank_select      = out_res_r.bank_select;
  assign out_ch.line_onehot      = out_res_r.line_onehot;
  assign out_ch.last             = out_res_r.last;

`ifndef SYNTHESIS
  // A column send always fetches row 0 into the shifter in the next cycle
  a_send_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FUNC_SEND)) |=> seq.ld_pixel)
    else $error("column send did not load row 0");

  // The final word of a command frees the input side in the next cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (seq.push && seq.last) |=> in_ch.ready)
    else $error("input not ready after last word");

  // Latch pulses and chip reset never share a word
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.chip_reset_pulse &&
                      (out_res_r.latch_before || out_res_r.latch_after)))
    else $error("latch and chip reset on one word");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
module tb;
  import lmcd_pkg::*;

  // Geometry of the matrix and of one run of shifted words
  localparam int MATRIX_SIZE   = 8;
  localparam int SEND_ROWS     = 8;
  localparam int GAIN_GROUPS   = 8;
  localparam int CHANNELS      = 3;
  localparam int RUN_WORDS     = SEND_ROWS * CHANNELS;
  localparam int NUM_GAINS     = 3;

  // Cycle budgets: settle after the last word (a pixel write leaves no word
  // behind), and the watchdog on silence
  localparam int SETTLE_CYCLES = 32;
  localparam int IDLE_LIMIT    = 2000;

  // Random part: a few gain settings, roughly this many commands under each
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 22;

  typedef struct packed {
    func_t      func;
    logic [2:0] column;
    logic [2:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_enable;
  } command_t;

  // Stall patterns of the word receiver
  typedef enum int {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_BURSTY
  } rx_pattern_t;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lmcd_in_if  in_ch ();
  lmcd_out_if out_ch ();

  // Shadow of the block: frame store, pin levels and gain registers
  logic [PIX_W-1:0]  frame_copy [MATRIX_SIZE*MATRIX_SIZE];
  logic              bank_copy;
  logic [7:0]        line_copy;
  logic [GAIN_W-1:0] gain_copy [NUM_GAINS];

  // Words the driver still owes, oldest first
  lmcd_result_t expected_words [$];

  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  // Receiver pattern state, touched only by the receiver process
  rx_pattern_t rx_pattern = RX_OPEN;
  int unsigned rx_tick    = 0;
  int unsigned rx_hold    = 0;

  led_matrix_column_driver_top #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: one time unit high, one low
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Bring the shadow to its post-reset state: blank frame, lines closed, bank
  // low, full gain on every channel
  task automatic clear_shadow();
    foreach (frame_copy[i]) frame_copy[i] = '0;
    bank_copy = 1'b0;
    line_copy = 8'h00;
    foreach (gain_copy[i]) gain_copy[i] = 6'd63;
  endtask

  // Apply one accepted command to the shadow and queue the words it causes
  function automatic void predict_words(command_t c);
    lmcd_result_t     w;
    logic [PIX_W-1:0] px;
    int               n;
    n = 0;
    case (c.func)
      FUNC_PIXEL: begin
        // Store only inside the matrix; nothing is emitted
        if (c.column < MATRIX_SIZE && c.row < MATRIX_SIZE)
          frame_copy[int'(c.column)*MATRIX_SIZE + int'(c.row)] = {c.blue, c.green, c.red};
      end
      FUNC_SEND: begin
        // Rows in order, blue then green then red; latch around the whole run
        for (int y = 0; y < SEND_ROWS; y++) begin
          px = (c.column < MATRIX_SIZE) ? frame_copy[int'(c.column)*MATRIX_SIZE + y] : '0;
          for (int ch = 0; ch < CHANNELS; ch++) begin
            w              = '0;
            w.kind         = KIND_SHIFT;
            w.shift_word   = px[PIX_W-1-DIGIT_W*ch -: DIGIT_W];
            w.word_bits    = DATA_WORD_BITS;
            w.latch_before = (n == 0);
            w.latch_after  = (n == RUN_WORDS-1);
            w.bank_select  = bank_copy;
            w.line_onehot  = line_copy;
            w.last         = (n == RUN_WORDS-1);
            expected_words.push_back(w);
            n++;
          end
        end
      end
      FUNC_INIT: begin
        // Init closes all lines and raises bank select before the first word
        line_copy = 8'h00;
        bank_copy = 1'b1;
        for (int g = 0; g < GAIN_GROUPS; g++) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            w                  = '0;
            w.kind             = KIND_SHIFT;
            w.shift_word       = 8'(gain_copy[ch]);
            w.word_bits        = GAIN_WORD_BITS;
            w.chip_reset_pulse = (n == 0);
            w.bank_select      = bank_copy;
            w.line_onehot      = line_copy;
            w.last             = (n == RUN_WORDS-1);
            expected_words.push_back(w);
            n++;
          end
        end
      end
      default: begin
        // Line select: open one line, or close all on disable or off-matrix
        if (c.line_enable && c.column < MATRIX_SIZE)
          line_copy = 8'(1 << c.column);
        else
          line_copy = 8'h00;
        w             = '0;
        w.kind        = KIND_LINE;
        w.word_bits   = NO_WORD_BITS;
        w.bank_select = bank_copy;
        w.line_onehot = line_copy;
        w.last        = 1'b1;
        expected_words.push_back(w);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic command_t make_command(func_t f, logic [2:0] column, logic [2:0] row,
                                            logic [7:0] red, logic [7:0] green,
                                            logic [7:0] blue, logic line_enable);
    command_t c;
    c.func        = f;
    c.column      = column;
    c.row         = row;
    c.red         = red;
    c.green       = green;
    c.blue        = blue;
    c.line_enable = line_enable;
    return c;
  endfunction

  // Every field random, so that the fields a command ignores still toggle
  function automatic command_t random_command(func_t f);
    return make_command(f, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one command and hold it until the transaction completes. The sender
  // runs in bursts; between bursts it drops valid for a random gap, or for none
  // at all, which gives stretches of back-to-back commands.
  task automatic send_command(command_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= c.func;
    in_ch.column      <= c.column;
    in_ch.row         <= c.row;
    in_ch.red         <= c.red;
    in_ch.green       <= c.green;
    in_ch.blue        <= c.blue;
    in_ch.line_enable <= c.line_enable;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_words(c);
    burst_left--;
  endtask

  // Drop valid, wait for every owed word, then let a possible trailing pixel
  // write finish inside the block before anything else touches it
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Configuration side
  // ---------------------------------------------------------------------------

  // One APB transfer: setup, then access until pready. psel stays high on exit
  // so that back-to-back transfers go straight into the next setup phase.
  task automatic apb_transfer(input logic is_write, input logic [1:0] index,
                              input logic [CFG_DATA_W-1:0] data,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= CFG_ADDR_W'({index, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  // Write all three gains, read them back, then release the bus. Only the low
  // six bits of a written value are kept.
  task automatic program_gains(logic [CFG_DATA_W-1:0] first, logic [CFG_DATA_W-1:0] second,
                               logic [CFG_DATA_W-1:0] third);
    logic [CFG_DATA_W-1:0] values [NUM_GAINS];
    logic [1:0]            regs   [NUM_GAINS];
    logic [CFG_DATA_W-1:0] rdata;
    values = '{first, second, third};
    regs   = '{REG_GAIN_FIRST, REG_GAIN_SECOND, REG_GAIN_THIRD};
    for (int i = 0; i < NUM_GAINS; i++) begin
      apb_transfer(1'b1, regs[i], values[i], rdata);
      gain_copy[i] = values[i][GAIN_W-1:0];
    end
    for (int i = 0; i < NUM_GAINS; i++) begin
      apb_transfer(1'b0, regs[i], '0, rdata);
      if (rdata[GAIN_W-1:0] !== gain_copy[i]) begin
        errors++;
        $display("%0t gain register %0d expected %0h actual %0h",
                 $time, i, gain_copy[i], rdata[GAIN_W-1:0]);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Word side: check each completed transaction, then advance the stall pattern
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_word(lmcd_result_t got);
    lmcd_result_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t unexpected word expected none actual %p", $time, got);
    end else begin
      want = expected_words.pop_front();
      check_field("kind",             8'(want.kind),             8'(got.kind));
      check_field("shift_word",       want.shift_word,           got.shift_word);
      check_field("word_bits",        8'(want.word_bits),        8'(got.word_bits));
      check_field("latch_before",     8'(want.latch_before),     8'(got.latch_before));
      check_field("latch_after",      8'(want.latch_after),      8'(got.latch_after));
      check_field("chip_reset_pulse", 8'(want.chip_reset_pulse), 8'(got.chip_reset_pulse));
      check_field("bank_select",      8'(want.bank_select),      8'(got.bank_select));
      check_field("line_onehot",      want.line_onehot,          got.line_onehot);
      check_field("last",             8'(want.last),             8'(got.last));
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_word({out_ch.kind, out_ch.shift_word, out_ch.word_bits, out_ch.latch_before,
                  out_ch.latch_after, out_ch.chip_reset_pulse, out_ch.bank_select,
                  out_ch.line_onehot, out_ch.last});
    // Pick a new random pattern on a tick counter so stalls land on every phase of a run
    rx_tick++;
    if (rx_tick % 64 == 0)
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: out_ch.ready <= (rx_tick % 5 >= 2);
      default: begin
        // Occasional long holds of a random length
        if (rx_hold != 0) begin
          rx_hold--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0)
            rx_hold = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Count cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: give up once the channels stay silent for too long
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Blank frame after reset, a line select and an init at the reset gains
  task automatic test_reset_state();
    send_command(make_command(FUNC_SEND, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_command(make_command(FUNC_LINE, 3'd3, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_command(make_command(FUNC_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // Corner pixels with extreme and mixed colours, then send both edge columns
  task automatic test_pixel_extremes();
    send_command(make_command(FUNC_PIXEL, 3'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_command(make_command(FUNC_PIXEL, 3'd0, 3'd7, 8'h00, 8'hAA, 8'h55, 1'b1));
    send_command(make_command(FUNC_PIXEL, 3'd7, 3'd7, 8'h01, 8'h80, 8'hFE, 1'b0));
    send_command(make_command(FUNC_PIXEL, 3'd7, 3'd0, 8'h00, 8'h00, 8'hFF, 1'b1));
    send_command(make_command(FUNC_SEND,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_command(make_command(FUNC_SEND,  3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // Edge lines, a close, and a send that must carry the open line
  task automatic test_line_select();
    send_command(make_command(FUNC_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_command(make_command(FUNC_LINE, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_command(make_command(FUNC_LINE, 3'd5, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_command(make_command(FUNC_LINE, 3'd2, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_command(make_command(FUNC_SEND, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // Zero gains, saturated and truncated writes, then mixed values
  task automatic test_gain_settings();
    settle_block();
    program_gains(32'd0, 32'd0, 32'd0);
    send_command(make_command(FUNC_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    settle_block();
    program_gains(32'hFFFF_FFFF, 32'h0000_0040, 32'h0000_002A);
    send_command(make_command(FUNC_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    settle_block();
    program_gains(32'd1, 32'd32, 32'd62);
    send_command(make_command(FUNC_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // One random sequence: mostly fill a column and send it, otherwise a line
  // select, an init or a command of any kind with random content
  task automatic random_sequence(inout int unsigned count);
    int unsigned pick;
    int unsigned fills;
    logic [2:0]  column;
    command_t    c;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      column = 3'($urandom_range(0, 7));
      fills  = $urandom_range(1, 6);
      repeat (fills) begin
        c        = random_command(FUNC_PIXEL);
        c.column = column;
        send_command(c);
        count++;
      end
      c        = random_command(FUNC_SEND);
      c.column = column;
      send_command(c);
    end else if (pick <= 7) begin
      send_command(random_command(FUNC_LINE));
    end else if (pick == 8) begin
      send_command(random_command(FUNC_INIT));
    end else begin
      send_command(random_command(func_t'($urandom_range(0, 3))));
    end
    count++;
  endtask

  // Random traffic under several random gain settings
  task automatic test_random_traffic();
    int unsigned count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      program_gains($urandom, $urandom, $urandom);
      count = 0;
      while (count < PHASE_ITEMS) random_sequence(count);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    // Drive every input to a known level from time zero
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_PIXEL;
    in_ch.column      = '0;
    in_ch.row         = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    in_ch.line_enable = 1'b0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    clear_shadow();

    // Hold reset, then release it on an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_pixel_extremes();
    test_line_select();
    test_gain_settings();
    test_random_traffic();

    // Drain the last words and give the block time to show any extra ones
    settle_block();

    if (errors == 0 && expected_words.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
